>>> hdl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/bgc_pkg.sv
package bgc_pkg;

    // Widths of the internal tick counters.
    localparam int TIMER_BITS    = 16;
    localparam int DEBOUNCE_BITS = 8;

    // Fixed widths of the configuration registers and port.
    localparam int CFG_DEB_W  = 8;
    localparam int CFG_TIM_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Compare widths wide enough for both a counter and its limit.
    localparam int TCMP_W = (TIMER_BITS > CFG_TIM_W) ? TIMER_BITS : CFG_TIM_W;
    localparam int DCMP_W = (DEBOUNCE_BITS > CFG_DEB_W) ? DEBOUNCE_BITS : CFG_DEB_W;

    typedef logic [TIMER_BITS-1:0]    tmr_t;
    typedef logic [DEBOUNCE_BITS-1:0] dbt_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_LOW  = 3'd0,
        REG_DEBOUNCE   = 3'd1,
        REG_LONG_PRESS = 3'd2,
        REG_DOUBLE_WIN = 3'd3
    } reg_idx_t;

    typedef struct packed {
        logic                 press_low;
        logic [CFG_DEB_W-1:0] debounce_ticks;
        logic [CFG_TIM_W-1:0] long_press_ticks;
        logic [CFG_TIM_W-1:0] double_window_ticks;
    } cfg_t;

    // Debouncer verdict for the current tick.
    typedef struct packed {
        logic pass;     // window closed, gestures may be judged
        logic pressed;  // debounced level counts as pressed
    } dbn_t;

    function automatic tmr_t sat_tmr(input tmr_t v);
        return (v == '1) ? v : v + tmr_t'(1);
    endfunction

    function automatic dbt_t sat_dbt(input dbt_t v);
        return (v == '1) ? v : v + dbt_t'(1);
    endfunction

endpackage

>>> hdl/button_gesture_classifier.sv
// Button gesture classifier. Each input item is one time tick carrying the raw
// pin level; each accepted item yields exactly one result item with an event
// code (none, single, double or long press) and the debounced held state. The
// block takes one item per clock cycle while in_stall is low: the debounce and
// gesture state are updated in the cycle an item is accepted, and the result is
// registered in the output entry. A second output entry catches one result while the
// downstream side stalls, so in_stall only rises once two results are waiting.
// Configuration registers (index 0 press_low, 1 debounce_ticks,
// 2 long_press_ticks, 3 double_window_ticks) are written through the cfg
// channel, which is always ready; writes to other indexes are ignored, and
// they should only be made while no item is in flight.
`include "assert_macros.svh"

module button_gesture_classifier
    import bgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Tick input channel.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  pin_level,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            event_res,
    output logic                  held_now,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg_reg;
    dbn_t   dbn;
    event_t ev;
    logic   held;
    logic   in_fire, out_fire;

    // Primary output entry and skid entry.
    logic   out_valid_reg, skid_valid_reg;
    event_t out_ev_reg, skid_ev_reg;
    logic   out_held_reg, skid_held_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign event_res = out_ev_reg;
    assign held_now  = out_held_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.press_low           <= 1'b1;
            cfg_reg.debounce_ticks      <= CFG_DEB_W'(30);
            cfg_reg.long_press_ticks    <= CFG_TIM_W'(1000);
            cfg_reg.double_window_ticks <= CFG_TIM_W'(300);
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_PRESS_LOW:  cfg_reg.press_low           <= cfg_data[0];
                REG_DEBOUNCE:   cfg_reg.debounce_ticks      <= cfg_data[CFG_DEB_W-1:0];
                REG_LONG_PRESS: cfg_reg.long_press_ticks    <= cfg_data[CFG_TIM_W-1:0];
                REG_DOUBLE_WIN: cfg_reg.double_window_ticks <= cfg_data[CFG_TIM_W-1:0];
                default: ;
            endcase
        end
    end

    bgc_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_fire),
        .sample         (pin_level),
        .press_low      (cfg_reg.press_low),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .dbn            (dbn)
    );

    bgc_gesture u_gesture (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (in_fire),
        .dbn                 (dbn),
        .long_press_ticks    (cfg_reg.long_press_ticks),
        .double_window_ticks (cfg_reg.double_window_ticks),
        .ev                  (ev),
        .held                (held)
    );

    // Result buffer: when the primary entry is free or being taken, it refills
    // from the skid entry first, else from the new item. Otherwise a new result
    // parks in the skid entry, which is known to be empty since in_stall is low.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_fire) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!out_valid_reg || out_fire) begin
            if (skid_valid_reg) begin
                out_ev_reg   <= skid_ev_reg;
                out_held_reg <= skid_held_reg;
            end else if (in_fire) begin
                out_ev_reg   <= ev;
                out_held_reg <= held;
            end
        end else if (in_fire) begin
            skid_ev_reg   <= ev;
            skid_held_reg <= held;
        end
    end

    // The skid entry is only ever filled behind a waiting primary entry.
    `ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A result that cannot leave while a new item arrives must be caught.
    `ASSERT_NEXT(a_skid_catches, in_fire && out_valid_reg && out_stall, skid_valid_reg)
    // A long press is reported while the button is still held.
    `ASSERT_NOW(a_long_while_held, out_valid_reg && out_ev_reg == EV_LONG, out_held_reg)
    // A double press is reported on a release.
    `ASSERT_NOW(a_double_on_release, out_valid_reg && out_ev_reg == EV_DOUBLE, !out_held_reg)

endmodule

>>> hdl/bgc_debounce.sv
module bgc_debounce
    import bgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 sample,
    input  logic                 press_low,
    input  logic [CFG_DEB_W-1:0] debounce_ticks,
    output dbn_t                 dbn
);

    logic prev_sample_reg, prev_sample_next;
    logic window_open_reg, window_open_next;
    dbt_t window_timer_reg, window_timer_next;
    logic stable_pressed_reg, stable_pressed_next;
    logic open_eff;
    dbt_t timer_eff;

    always_comb begin
        open_eff            = window_open_reg || (sample != prev_sample_reg);
        timer_eff           = window_open_reg ? window_timer_reg : '0;
        prev_sample_next    = sample;
        window_open_next    = window_open_reg;
        window_timer_next   = window_timer_reg;
        stable_pressed_next = stable_pressed_reg;
        dbn.pass            = 1'b1;
        if (open_eff) begin
            if (DCMP_W'(timer_eff) >= DCMP_W'(debounce_ticks)) begin
                // The window closes and the level sampled now is trusted.
                stable_pressed_next = press_low ? !sample : sample;
                window_open_next    = 1'b0;
                window_timer_next   = timer_eff;
            end else begin
                window_timer_next = sat_dbt(timer_eff);
                window_open_next  = 1'b1;
                dbn.pass          = 1'b0;
            end
        end
        dbn.pressed = stable_pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_sample_reg    <= 1'b0;
            window_open_reg    <= 1'b0;
            window_timer_reg   <= '0;
            stable_pressed_reg <= 1'b0;
        end else if (step) begin
            prev_sample_reg    <= prev_sample_next;
            window_open_reg    <= window_open_next;
            window_timer_reg   <= window_timer_next;
            stable_pressed_reg <= stable_pressed_next;
        end
    end

endmodule

>>> hdl/bgc_gesture.sv
module bgc_gesture
    import bgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dbn_t                 dbn,
    input  logic [CFG_TIM_W-1:0] long_press_ticks,
    input  logic [CFG_TIM_W-1:0] double_window_ticks,
    output event_t               ev,
    output logic                 held
);

    logic is_held_reg, is_held_next;
    logic long_done_reg, long_done_next;
    logic await_second_reg, await_second_next;
    tmr_t hold_timer_reg, hold_timer_next;
    tmr_t release_timer_reg, release_timer_next;
    tmr_t hold_inc, rel_inc;

    always_comb begin
        hold_inc           = is_held_reg ? sat_tmr(hold_timer_reg) : hold_timer_reg;
        rel_inc            = await_second_reg ? sat_tmr(release_timer_reg) : release_timer_reg;
        is_held_next       = is_held_reg;
        long_done_next     = long_done_reg;
        await_second_next  = await_second_reg;
        hold_timer_next    = hold_inc;
        release_timer_next = rel_inc;
        ev                 = EV_NONE;
        if (dbn.pass) begin
            if (!is_held_reg && dbn.pressed) begin
                is_held_next    = 1'b1;
                hold_timer_next = '0;
                long_done_next  = 1'b0;
            end else if (is_held_reg && !dbn.pressed) begin
                is_held_next = 1'b0;
                if (long_done_reg) begin
                    // Release after a long press counts as no click.
                    long_done_next    = 1'b0;
                    await_second_next = 1'b0;
                end else if (!await_second_reg) begin
                    await_second_next  = 1'b1;
                    release_timer_next = '0;
                end else if (TCMP_W'(rel_inc) <= TCMP_W'(double_window_ticks)) begin
                    await_second_next = 1'b0;
                    ev                = EV_DOUBLE;
                end else begin
                    // Late second release: report the first and wait again.
                    release_timer_next = '0;
                    await_second_next  = 1'b1;
                    ev                 = EV_SINGLE;
                end
            end else if (is_held_reg && !long_done_reg &&
                         TCMP_W'(hold_inc) >= TCMP_W'(long_press_ticks)) begin
                long_done_next    = 1'b1;
                await_second_next = 1'b0;
                ev                = EV_LONG;
            end else if (!is_held_reg && await_second_reg &&
                         TCMP_W'(rel_inc) >= TCMP_W'(double_window_ticks)) begin
                await_second_next = 1'b0;
                ev                = EV_SINGLE;
            end
        end
        held = is_held_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            is_held_reg       <= 1'b0;
            long_done_reg     <= 1'b0;
            await_second_reg  <= 1'b0;
            hold_timer_reg    <= '0;
            release_timer_reg <= '0;
        end else if (step) begin
            is_held_reg       <= is_held_next;
            long_done_reg     <= long_done_next;
            await_second_reg  <= await_second_next;
            hold_timer_reg    <= hold_timer_next;
            release_timer_reg <= release_timer_next;
        end
    end

endmodule
